### sv/max_subarray_linear_scan_macros.svh
// Assertion macros for the max subarray scan block.
// Each takes a label, an antecedent and a consequent; clk and rst_n come from the
// scope of the user.
`ifndef MAX_SUBARRAY_LINEAR_SCAN_MACROS_SVH
`define MAX_SUBARRAY_LINEAR_SCAN_MACROS_SVH

`ifndef SYNTHESIS

`define MSLS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("msls check failed");

`define MSLS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("msls check failed");

`else

`define MSLS_ASSERT_SAME(label, ante, cons)

`define MSLS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/msls_pkg.sv
package msls_pkg;

  localparam int unsigned MAX_LENGTH    = 65536;
  localparam int unsigned ELEMENT_WIDTH = 16;
  localparam int unsigned IDX_W         = $clog2(MAX_LENGTH);
  localparam int unsigned SUM_W         = 32;
  localparam int unsigned ACC_W         = SUM_W + 1;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic        [IDX_W-1:0]         idx_t;
  typedef logic signed [SUM_W-1:0]         sum_t;
  typedef logic signed [ACC_W-1:0]         acc_t;
  typedef logic        [QPTR_W-1:0]        qptr_t;
  typedef logic        [QCNT_W-1:0]        qcnt_t;

  localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [31:0] best_sum;
    logic        [15:0] start_index;
    logic        [15:0] end_index;
  } out_t;

  // classified element as it waits in the queue
  typedef struct packed {
    elem_t elem;
    logic  last;
  } item_t;

  // handshake between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_fwd_t;

  function automatic idx_t next_idx(idx_t i);
    return (i == idx_t'(MAX_LENGTH - 1)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic qptr_t next_qptr(qptr_t p);
    return (p == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + qptr_t'(1);
  endfunction

endpackage

### sv/max_subarray_linear_scan.sv
// Streaming maximum-subarray (Kadane) scan. Elements arrive one per beat on the in_ channel,
// the final element of an array flagged by last; one result beat (best sum, first and last
// index of the earliest best run) follows each last beat, after which the scan starts afresh.
// Sustained rate is one element per clock unless a last beat waits on a stalled result: the
// scan stage does one 33-bit add, a saturate and a compare per cycle. A two-entry queue sits
// between the input and scan stages; a result is registered when the scan stage takes its
// last element from the queue. A stalled result holds back the next last beat and all behind
// it. Indices wrap at MAX_LENGTH; the sum saturates at the largest positive 32-bit value.
`include "max_subarray_linear_scan_macros.svh"

module max_subarray_linear_scan (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  msls_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output msls_pkg::out_t out_data
);

  msls_pkg::q_fwd_t q_fwd;
  logic             q_ready;

  msls_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_fwd    (q_fwd),
    .q_ready  (q_ready)
  );

  msls_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_fwd     (q_fwd),
    .q_ready   (q_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // a full queue always offers a beat to the scan stage
  `MSLS_ASSERT_SAME(a_full_has_data, !in_ready, q_fwd.valid)
  // a beat pushed without a pop leaves the queue non-empty
  `MSLS_ASSERT_NEXT(a_push_visible, in_valid && in_ready && !(q_fwd.valid && q_ready),
                    q_fwd.valid)
  // a taken last beat always yields a result beat
  `MSLS_ASSERT_NEXT(a_last_gives_result, q_fwd.valid && q_ready && q_fwd.item.last, out_valid)
  // ordinary elements flow past a stalled result
  `MSLS_ASSERT_SAME(a_nonlast_flows, q_fwd.valid && !q_fwd.item.last, q_ready)

endmodule

### sv/msls_front.sv
module msls_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  msls_pkg::in_t    in_data,
  output msls_pkg::q_fwd_t q_fwd,
  input  logic             q_ready
);

  msls_pkg::item_t ent_r [msls_pkg::QUEUE_DEPTH];
  msls_pkg::qptr_t wr_ptr_r, wr_ptr_nxt;
  msls_pkg::qptr_t rd_ptr_r, rd_ptr_nxt;
  msls_pkg::qcnt_t cnt_r, cnt_nxt;
  msls_pkg::item_t cls_item;
  logic            push, pop;

  // keep only the low element bits, sign taken from the top one of them
  always_comb begin
    cls_item.elem = msls_pkg::elem_t'(in_data.value[msls_pkg::ELEMENT_WIDTH-1:0]);
    cls_item.last = in_data.last;
  end

  assign in_ready    = (cnt_r != msls_pkg::qcnt_t'(msls_pkg::QUEUE_DEPTH));
  assign q_fwd.valid = (cnt_r != '0);
  assign q_fwd.item  = ent_r[rd_ptr_r];
  assign push        = in_valid && in_ready;
  assign pop         = q_fwd.valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? msls_pkg::next_qptr(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? msls_pkg::next_qptr(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + msls_pkg::qcnt_t'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - msls_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

### sv/msls_back.sv
module msls_back (
  input  logic             clk,
  input  logic             rst_n,
  input  msls_pkg::q_fwd_t q_fwd,
  output logic             q_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output msls_pkg::out_t   out_data
);

  msls_pkg::sum_t run_sum_r, run_sum_nxt;
  msls_pkg::idx_t run_start_r, run_start_nxt;
  msls_pkg::sum_t best_r, best_nxt;
  msls_pkg::idx_t best_start_r, best_start_nxt;
  msls_pkg::idx_t best_end_r, best_end_nxt;
  msls_pkg::idx_t pos_r, pos_nxt;
  logic           out_valid_r, out_valid_nxt;
  msls_pkg::out_t out_data_r;

  msls_pkg::acc_t acc;
  msls_pkg::sum_t sum_sat;
  logic           take, better;
  msls_pkg::sum_t upd_best;
  msls_pkg::idx_t upd_start, upd_end;

  // a non-last beat never touches the output register, so it may pass a held result
  assign q_ready = !q_fwd.item.last || !out_valid_r || out_ready;
  assign take    = q_fwd.valid && q_ready;

  always_comb begin
    // running sum is never negative here, so only the top end can overflow
    acc     = msls_pkg::acc_t'(run_sum_r) + msls_pkg::acc_t'(q_fwd.item.elem);
    sum_sat = (acc > msls_pkg::acc_t'(msls_pkg::SUM_MAX)) ? msls_pkg::SUM_MAX
                                                          : msls_pkg::sum_t'(acc);
    better    = (sum_sat > best_r);
    upd_best  = better ? sum_sat     : best_r;
    upd_start = better ? run_start_r : best_start_r;
    upd_end   = better ? pos_r       : best_end_r;

    run_sum_nxt    = run_sum_r;
    run_start_nxt  = run_start_r;
    best_nxt       = best_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = out_valid_r && !out_ready;

    if (take) begin
      if (q_fwd.item.last) begin
        run_sum_nxt    = '0;
        run_start_nxt  = '0;
        best_nxt       = msls_pkg::SUM_MIN;
        best_start_nxt = '0;
        best_end_nxt   = '0;
        pos_nxt        = '0;
        out_valid_nxt  = 1'b1;
      end else begin
        best_nxt       = upd_best;
        best_start_nxt = upd_start;
        best_end_nxt   = upd_end;
        pos_nxt        = msls_pkg::next_idx(pos_r);
        if (sum_sat[msls_pkg::SUM_W-1]) begin
          run_sum_nxt   = '0;
          run_start_nxt = msls_pkg::next_idx(pos_r);
        end else begin
          run_sum_nxt   = sum_sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r    <= '0;
      run_start_r  <= '0;
      best_r       <= msls_pkg::SUM_MIN;
      best_start_r <= '0;
      best_end_r   <= '0;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      run_sum_r    <= run_sum_nxt;
      run_start_r  <= run_start_nxt;
      best_r       <= best_nxt;
      best_start_r <= best_start_nxt;
      best_end_r   <= best_end_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_fwd.item.last) begin
      out_data_r.best_sum    <= 32'(upd_best);
      out_data_r.start_index <= 16'(upd_start);
      out_data_r.end_index   <= 16'(upd_end);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/max_subarray_linear_scan_tb.sv
module max_subarray_linear_scan_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ELEMENTS = 1750;
  localparam int LONG_HOLD = 400;

  typedef enum int {MIX_FULL, MIX_SMALL, MIX_EDGE, MIX_NEG, MIX_POS} mix_e;

  typedef struct {
    msls_pkg::in_t beat;
    bit            drain;   // hold this beat back until every result so far has come
  } element_beat_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  msls_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  msls_pkg::out_t out_data;

  max_subarray_linear_scan dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  element_beat_t  element_q[$];
  msls_pkg::out_t best_run_q[$];

  // scan state mirrored from the block
  longint      run_total;
  longint      best_total;
  logic [15:0] run_first;
  logic [15:0] best_first;
  logic [15:0] best_last;
  logic [15:0] cursor;

  logic in_took;
  int   mismatches;
  int   results_seen;
  int   elements_taken;
  int   quiet_cycles;
  int   tx_gap;
  int   tx_calm_left;
  bit   tx_calm;
  int   rx_gap;
  int   rx_calm_left;
  bit   rx_calm;
  int   hold_left;
  bit   hold_done;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic clear_scan();
    run_total  = 0;
    run_first  = '0;
    best_total = longint'(msls_pkg::SUM_MIN);
    best_first = '0;
    best_last  = '0;
    cursor     = '0;
  endtask

  task automatic scan_element(msls_pkg::in_t beat);
    msls_pkg::out_t res;
    run_total += longint'($signed(beat.value));
    if (run_total > longint'(msls_pkg::SUM_MAX))
      run_total = longint'(msls_pkg::SUM_MAX);
    // strict compare: an equal later run never displaces the earlier best
    if (run_total > best_total) begin
      best_total = run_total;
      best_first = run_first;
      best_last  = cursor;
    end
    if (run_total < 0) begin
      run_total = 0;
      run_first = cursor + 16'd1;
    end
    cursor = cursor + 16'd1;
    if (beat.last) begin
      res.best_sum    = best_total[31:0];
      res.start_index = best_first;
      res.end_index   = best_last;
      best_run_q.push_back(res);
      clear_scan();
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      return 0;
    if (r < 92)
      return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic push_beat(logic [15:0] v, bit last, bit drain);
    element_beat_t e;
    e.beat.value = v;
    e.beat.last  = last;
    e.drain      = drain;
    element_q.push_back(e);
  endtask

  task automatic queue_array(int len, mix_e mix, bit drain_first);
    logic [15:0] v;
    for (int i = 0; i < len; i++) begin
      case (mix)
        MIX_FULL:  v = 16'($urandom_range(0, 65535));
        MIX_SMALL: v = 16'(int'($urandom_range(0, 80)) - 40);
        MIX_EDGE: begin
          case ($urandom_range(4))
            0: v = 16'h8000;
            1: v = 16'h7fff;
            2: v = 16'hffff;
            3: v = 16'h0001;
            default: v = 16'h0000;
          endcase
        end
        MIX_NEG: begin
          v = 16'(-int'($urandom_range(1, 3000)));
          if ($urandom_range(7) == 0)
            v = 16'($urandom_range(0, 4000));
        end
        default: begin
          v = 16'($urandom_range(0, 3000));
          if ($urandom_range(3) == 0)
            v = 16'(-int'($urandom_range(1, 5000)));
        end
      endcase
      push_beat(v, i == len - 1, drain_first && i == 0);
    end
  endtask

  // sender: new beat at the falling edge once the previous one has gone
  always @(negedge clk) begin : feed_elements
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (tx_calm_left > 0) begin
        tx_calm_left--;
      end else begin
        tx_calm_left = 150;
        tx_calm      = ($urandom_range(99) < 30);
      end
      if (!in_valid || in_took) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (element_q.size() != 0 &&
                     !(element_q[0].drain && best_run_q.size() != 0)) begin
          in_data  <= element_q[0].beat;
          in_valid <= 1'b1;
          void'(element_q.pop_front());
          if (!tx_calm)
            tx_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off
  always @(negedge clk) begin : take_results
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_calm_left > 0) begin
        rx_calm_left--;
      end else begin
        rx_calm_left = 150;
        rx_calm      = ($urandom_range(99) < 30);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && results_seen >= 25) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!rx_calm)
          rx_gap = pick_gap();
      end
    end
  end

  // checks, prediction and watchdog, all on the rising edge
  always @(posedge clk) begin : watch_beats
    msls_pkg::out_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (best_run_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: sum %0d start %0d end %0d",
                     $signed(out_data.best_sum), out_data.start_index, out_data.end_index);
        end else begin
          want = best_run_q.pop_front();
          if (out_data.best_sum !== want.best_sum ||
              out_data.start_index !== want.start_index ||
              out_data.end_index !== want.end_index) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       results_seen, $signed(want.best_sum), want.start_index, want.end_index,
                       $signed(out_data.best_sum), out_data.start_index, out_data.end_index);
          end
        end
      end
      if (in_valid && in_ready) begin
        elements_taken <= elements_taken + 1;
        scan_element(in_data);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no beat moved for %0d cycles, %0d results outstanding",
                 quiet_cycles, best_run_q.size());
        $display("max_subarray_linear_scan_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : run_test
    int   random_left;
    int   len;
    mix_e mix;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_ready    = 1'b0;
    in_took      = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    elements_taken = 0;
    quiet_cycles = 0;
    tx_gap = 0;
    tx_calm_left = 0;
    tx_calm = 1'b0;
    rx_gap = 0;
    rx_calm_left = 0;
    rx_calm = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    clear_scan();

    // directed arrays: extremes, all negative, ties, run restart
    push_beat(16'h7fff, 1'b1, 1'b0);
    push_beat(16'h8000, 1'b1, 1'b0);
    push_beat(-16'sd5, 1'b0, 1'b0);
    push_beat(-16'sd3, 1'b0, 1'b0);
    push_beat(-16'sd7, 1'b1, 1'b0);
    push_beat(16'sd3, 1'b0, 1'b0);
    push_beat(-16'sd3, 1'b0, 1'b0);
    push_beat(16'sd3, 1'b1, 1'b0);
    push_beat(16'sd2, 1'b0, 1'b0);
    push_beat(-16'sd5, 1'b0, 1'b0);
    push_beat(16'sd4, 1'b1, 1'b0);
    push_beat(16'h7fff, 1'b0, 1'b0);
    push_beat(16'h7fff, 1'b0, 1'b0);
    push_beat(16'h8000, 1'b0, 1'b0);
    push_beat(16'hffff, 1'b1, 1'b0);
    push_beat(16'h0000, 1'b0, 1'b0);
    push_beat(16'h0000, 1'b1, 1'b0);

    // random arrays, mostly short; the first waits for the directed results
    random_left = RANDOM_ELEMENTS;
    while (random_left > 0) begin
      len = ($urandom_range(99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 60);
      mix = mix_e'($urandom_range(0, 4));
      queue_array(len, mix, random_left == RANDOM_ELEMENTS || $urandom_range(99) < 3);
      random_left -= len;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (element_q.size() == 0 && !in_valid);
    wait (best_run_q.size() == 0);
    repeat (20) @(posedge clk);

    $display("scanned %0d elements over %0d arrays: directed edge cases and random mixes",
             elements_taken, results_seen);
    $display("long receiver hold-off %0s, %0d mismatches, %0d results left",
             hold_done ? "done" : "missed", mismatches, best_run_q.size());
    if (mismatches == 0 && best_run_q.size() == 0)
      $display("max_subarray_linear_scan_tb: PASS");
    else
      $display("max_subarray_linear_scan_tb: FAIL");
    $finish;
  end

endmodule
